>>> design/hob_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hob_pkg: shared definitions for the harmonic oscillator bank
// Field widths, register indexes, item classes, the queue entry type and the
// quarter-wave sine table builder.
// ---------------------------------------------------------------------------
package hob_pkg;

  localparam int PITCH_W         = 24;
  localparam int AMP_W           = 16;
  localparam int HARM_W          = 8;
  localparam int RATE_W          = 18;
  localparam int TURNS_W         = 32;
  localparam int PHASE_W         = 32;
  localparam int KP_W            = PITCH_W + HARM_W;
  localparam int STEP_FULL_W     = PITCH_W + TURNS_W;

  localparam int MAX_HARMONICS   = 128;
  localparam int SINE_TABLE_BITS = 10;
  localparam int QTR_SIZE        = 1 << SINE_TABLE_BITS;
  localparam int ROM_ADDR_W      = SINE_TABLE_BITS + 1;
  localparam int SINE_W          = 15;
  localparam int PROD_W          = SINE_W + 2 + AMP_W;

  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 32;

  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [RATE_W-1:0]  SAMPLE_RATE_RESET  = RATE_W'(48000);
  localparam logic [TURNS_W-1:0] TURNS_PER_HZ_RESET = TURNS_W'(22906492);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SAMPLE_RATE  = 2'd0,
    REG_TURNS_PER_HZ = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CLS_NORMAL,
    CLS_MUTED,
    CLS_SILENT
  } cls_t;

  typedef struct packed {
    logic [PHASE_W-1:0] step;
    logic               new_frame;
    logic [AMP_W-1:0]   amplitude;
    logic [HARM_W-1:0]  harmonic;
    cls_t               cls;
  } entry_t;

  typedef logic [SINE_W-1:0] sine_rom_t [0:QTR_SIZE];

  function automatic logic [SINE_W-1:0] quarter_entry(input int unsigned i);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    begin
      x    = (64'd1686629713 * 64'(i)) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      sum  = $signed(x);
      term = ((x * x2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd272;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd342;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd420;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd506;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd600;
      sum  = sum + $signed(term);
      if (sum < 64'sd0) begin
        sum = 64'sd0;
      end
      if (sum > 64'sh40000000) begin
        sum = 64'sh40000000;
      end
      v = ($unsigned(sum) * 64'd32767 + 64'd536870912) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      return v[SINE_W-1:0];
    end
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    begin
      for (int i = 0; i <= QTR_SIZE; i++) begin
        rom[i] = quarter_entry(i);
      end
      return rom;
    end
  endfunction

endpackage
`default_nettype wire

>>> design/hob_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hob_front: input stage and classifier
// Holds the configuration registers, takes input items, computes the phase
// step and the Nyquist test, and pushes classified entries into the queue.
// ---------------------------------------------------------------------------
module hob_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [hob_pkg::PITCH_W-1:0]       pitch,
  input  wire logic signed [hob_pkg::AMP_W-1:0]  amplitude,
  input  wire logic [hob_pkg::HARM_W-1:0]        harmonic,
  input  wire logic                              new_frame,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [hob_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [hob_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                   q_push,
  output hob_pkg::entry_t                        q_data,
  input  wire logic                              q_full
);

  logic [hob_pkg::RATE_W-1:0]      sample_rate;
  logic [hob_pkg::TURNS_W-1:0]     turns_per_hz;

  logic                            f_valid;
  logic [hob_pkg::PITCH_W-1:0]     f_pitch;
  logic [hob_pkg::AMP_W-1:0]       f_amp;
  logic [hob_pkg::HARM_W-1:0]      f_harm;
  logic                            f_new_frame;

  logic                            accept;
  logic [hob_pkg::STEP_FULL_W-1:0] step_full;
  logic [hob_pkg::KP_W-1:0]        kp;
  logic [hob_pkg::KP_W:0]          nyq_lhs;
  logic [hob_pkg::KP_W:0]          nyq_rhs;
  logic                            muted;
  hob_pkg::cls_t                   cls;

  assign cfg_ready = 1'b1;
  assign in_stall  = f_valid && q_full;
  assign q_push    = f_valid && !q_full;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate  <= hob_pkg::SAMPLE_RATE_RESET;
      turns_per_hz <= hob_pkg::TURNS_PER_HZ_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hob_pkg::REG_SAMPLE_RATE:  sample_rate  <= cfg_data[hob_pkg::RATE_W-1:0];
        hob_pkg::REG_TURNS_PER_HZ: turns_per_hz <= cfg_data[hob_pkg::TURNS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_pitch     <= pitch;
      f_amp       <= amplitude;
      f_harm      <= harmonic;
      f_new_frame <= new_frame;
    end
  end

  assign step_full = hob_pkg::STEP_FULL_W'(f_pitch) * hob_pkg::STEP_FULL_W'(turns_per_hz);
  assign kp        = hob_pkg::KP_W'(f_harm) * hob_pkg::KP_W'(f_pitch);
  assign nyq_lhs   = {kp, 1'b0};
  assign nyq_rhs   = (hob_pkg::KP_W + 1)'({sample_rate, 8'd0});
  assign muted     = nyq_lhs >= nyq_rhs;

  always_comb begin
    if (f_harm > hob_pkg::HARM_W'(hob_pkg::MAX_HARMONICS)) begin
      cls = hob_pkg::CLS_SILENT;
    end else if (muted) begin
      cls = hob_pkg::CLS_MUTED;
    end else begin
      cls = hob_pkg::CLS_NORMAL;
    end
  end

  always_comb begin
    q_data.step      = step_full[16 +: hob_pkg::PHASE_W];
    q_data.new_frame = f_new_frame;
    q_data.amplitude = f_amp;
    q_data.harmonic  = f_harm;
    q_data.cls       = cls;
  end

endmodule
`default_nettype wire

>>> design/hob_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hob_queue: entry queue between front and back
// Small register FIFO that lets the front and the back stall on their own.
// ---------------------------------------------------------------------------
module hob_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire hob_pkg::entry_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output hob_pkg::entry_t      pop_data,
  output logic                 empty
);

  hob_pkg::entry_t                  slots [hob_pkg::QUEUE_DEPTH];
  logic [hob_pkg::QUEUE_PTR_W-1:0]  wr_ptr;
  logic [hob_pkg::QUEUE_PTR_W-1:0]  rd_ptr;
  logic [hob_pkg::QUEUE_CNT_W-1:0]  count;
  logic                             do_push;
  logic                             do_pop;

  assign full     = count == hob_pkg::QUEUE_CNT_W'(hob_pkg::QUEUE_DEPTH);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> design/hob_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// hob_back: phase accumulator and sine synthesis pipeline
// Advances the shared phase, forms the harmonic phase, reads the quarter-wave
// table, scales by amplitude and rounds with saturation into the output
// register, with muted and silent items forced to zero.
// ---------------------------------------------------------------------------
module hob_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              q_empty,
  input  wire hob_pkg::entry_t                   q_data,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [hob_pkg::AMP_W-1:0]       sample_value,
  output logic [hob_pkg::HARM_W-1:0]             harmonic_out,
  output logic                                   above_nyquist
);

  localparam hob_pkg::sine_rom_t SineRom = hob_pkg::build_sine_rom();

  logic                                 adv;

  logic [hob_pkg::PHASE_W-1:0]          phase;
  logic [hob_pkg::PHASE_W-1:0]          phase_next;

  logic                                 v1;
  logic [hob_pkg::PHASE_W-1:0]          ph1;
  logic [hob_pkg::AMP_W-1:0]            amp1;
  logic [hob_pkg::HARM_W-1:0]           harm1;
  hob_pkg::cls_t                        cls1;

  logic                                 v2;
  logic [hob_pkg::PHASE_W-1:0]          hph2;
  logic [hob_pkg::AMP_W-1:0]            amp2;
  logic [hob_pkg::HARM_W-1:0]           harm2;
  hob_pkg::cls_t                        cls2;

  logic [hob_pkg::SINE_TABLE_BITS-1:0]  idx;
  logic [hob_pkg::ROM_ADDR_W-1:0]       rom_addr;

  logic                                 v3;
  logic [hob_pkg::SINE_W-1:0]           rom_q;
  logic                                 neg3;
  logic [hob_pkg::AMP_W-1:0]            amp3;
  logic [hob_pkg::HARM_W-1:0]           harm3;
  hob_pkg::cls_t                        cls3;

  logic signed [hob_pkg::SINE_W+1:0]    sine_s;
  logic signed [hob_pkg::PROD_W-1:0]    prod_c;

  logic                                 v4;
  logic signed [hob_pkg::PROD_W-1:0]    prod4;
  logic [hob_pkg::HARM_W-1:0]           harm4;
  hob_pkg::cls_t                        cls4;

  logic signed [hob_pkg::PROD_W:0]      rnd;
  logic signed [hob_pkg::PROD_W:0]      shifted;
  logic signed [hob_pkg::AMP_W-1:0]     sat;
  logic signed [hob_pkg::AMP_W-1:0]     value_next;

  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && !q_empty;

  assign phase_next = q_data.new_frame ? phase + q_data.step : phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      if (q_pop) begin
        phase <= phase_next;
      end
      v1        <= q_pop;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ph1   <= phase_next;
      amp1  <= q_data.amplitude;
      harm1 <= q_data.harmonic;
      cls1  <= q_data.cls;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hph2  <= hob_pkg::PHASE_W'(harm1) * ph1;
      amp2  <= amp1;
      harm2 <= harm1;
      cls2  <= cls1;
    end
  end

  assign idx      = hph2[hob_pkg::PHASE_W-3 -: hob_pkg::SINE_TABLE_BITS];
  assign rom_addr = hph2[hob_pkg::PHASE_W-2]
                  ? hob_pkg::ROM_ADDR_W'(hob_pkg::QTR_SIZE) - {1'b0, idx}
                  : {1'b0, idx};

  always_ff @(posedge clk) begin
    if (adv) begin
      rom_q <= SineRom[rom_addr];
      neg3  <= hph2[hob_pkg::PHASE_W-1];
      amp3  <= amp2;
      harm3 <= harm2;
      cls3  <= cls2;
    end
  end

  assign sine_s = neg3 ? -$signed({2'b00, rom_q}) : $signed({2'b00, rom_q});
  assign prod_c = sine_s * $signed(amp3);

  always_ff @(posedge clk) begin
    if (adv) begin
      prod4 <= prod_c;
      harm4 <= harm3;
      cls4  <= cls3;
    end
  end

  assign rnd     = (hob_pkg::PROD_W + 1)'(prod4) + (hob_pkg::PROD_W + 1)'(16384);
  assign shifted = rnd >>> 15;

  always_comb begin
    if (shifted > (hob_pkg::PROD_W + 1)'(32767)) begin
      sat = 16'sh7FFF;
    end else if (shifted < -(hob_pkg::PROD_W + 1)'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = shifted[hob_pkg::AMP_W-1:0];
    end
  end

  assign value_next = (cls4 == hob_pkg::CLS_NORMAL) ? sat : '0;

  always_ff @(posedge clk) begin
    if (adv) begin
      sample_value  <= value_next;
      harmonic_out  <= harm4;
      above_nyquist <= cls4 == hob_pkg::CLS_MUTED;
    end
  end

endmodule
`default_nettype wire

>>> design/harmonic_oscillator_bank.sv
`default_nettype none
// ---------------------------------------------------------------------------
// harmonic_oscillator_bank: additive harmonic sine oscillator bank
// Each item yields one saturated sine sample of one harmonic. The block takes
// one item per cycle while its four-entry queue has room and returns one
// result per cycle while the output is not stalled; a result passes from the
// input register, which loads at the edge that takes its item, through the
// queue slot and the five back-end stages in turn.
// The phase accumulator is the only loop that ties one item to the next.
// The sine table is a constant ROM, so the block is ready straight out of
// reset. Write configuration only while idle.
// ---------------------------------------------------------------------------
module harmonic_oscillator_bank (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [hob_pkg::PITCH_W-1:0]       pitch,
  input  wire logic signed [hob_pkg::AMP_W-1:0]  amplitude,
  input  wire logic [hob_pkg::HARM_W-1:0]        harmonic,
  input  wire logic                              new_frame,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [hob_pkg::AMP_W-1:0]       sample_value,
  output logic [hob_pkg::HARM_W-1:0]             harmonic_out,
  output logic                                   above_nyquist,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [hob_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [hob_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic            q_push;
  hob_pkg::entry_t q_push_data;
  logic            q_full;
  logic            q_pop;
  hob_pkg::entry_t q_pop_data;
  logic            q_empty;

  hob_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pitch     (pitch),
    .amplitude (amplitude),
    .harmonic  (harmonic),
    .new_frame (new_frame),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_data    (q_push_data),
    .q_full    (q_full)
  );

  hob_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  hob_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_data        (q_pop_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample_value  (sample_value),
    .harmonic_out  (harmonic_out),
    .above_nyquist (above_nyquist)
  );

endmodule
`default_nettype wire
